// ----- hdl/generational_handle_allocator_defines.svh -----
// assertion macros shared by the generational handle allocator rtl
// no dependencies; expects aclk and aresetn in the including module
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GHA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gha assertion failed");

// next-cycle implication, checked outside reset
`define GHA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gha assertion failed");

`endif

// ----- hdl/gha_pkg.sv -----
// shared types and constants for the generational handle allocator
// no dependencies
`default_nettype none

package gha_pkg;

    localparam int SLOTS       = 1024;
    localparam int GEN_MODULUS = 65536;

    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int GEN_W    = 16;
    localparam int TYPE_W   = 4;
    localparam int SUB_W    = 12;
    localparam int HANDLE_W = 42;
    localparam int HIDX_LSB = 32;
    localparam int HIDX_W   = HANDLE_W - HIDX_LSB;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = ((SUB_W + HANDLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((HANDLE_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_BORROW = 2'd0,
        MODE_RETURN = 2'd1,
        MODE_QUERY  = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_INVALID   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STK,
        ST_GEN,
        ST_FIN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic stk_rd;
        logic gen_rd_in;
        logic gen_rd_stk;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] in_mode;
        logic              free_empty;
        logic              out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- hdl/gha_ram.sv -----
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`default_nettype none

module gha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/gha_ctrl.sv -----
// sequencing state machine of the handle allocator
// depends on gha_pkg
`default_nettype none

module gha_ctrl
    import gha_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (sts.in_mode)
                        MODE_BORROW: state_next = sts.free_empty ? ST_FIN : ST_STK;
                        MODE_RETURN: state_next = ST_GEN;
                        MODE_QUERY:  state_next = ST_GEN;
                        default:     state_next = ST_FIN;
                    endcase
                end
            end
            ST_STK:  state_next = ST_GEN;
            ST_GEN:  state_next = ST_FIN;
            ST_FIN: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.capture   = s_tvalid;
                cmd.stk_rd    = s_tvalid && (sts.in_mode == MODE_BORROW) && !sts.free_empty;
                cmd.gen_rd_in = s_tvalid
                    && ((sts.in_mode == MODE_RETURN) || (sts.in_mode == MODE_QUERY));
            end
            ST_STK:  cmd.gen_rd_stk = 1'b1;
            ST_GEN:  ;
            ST_FIN:  cmd.commit = sts.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/gha_dp.sv -----
// datapath of the handle allocator: counters, generation and free-stack rams,
// item capture and result register; depends on gha_pkg, gha_ram and the defines header
`default_nettype none
`include "generational_handle_allocator_defines.svh"

module gha_dp
    import gha_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    input  wire logic [MODE_W-1:0]      s_tuser,
    input  wire logic                   cfg_valid,
    input  wire logic [TYPE_W-1:0]      cfg_data,
    output logic      [M_TDATA_W-1:0]   m_tdata,
    output logic      [STATUS_W-1:0]    m_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire cmd_t                   cmd,
    output sts_t                        sts
);

    localparam int HANDLE_LSB = SUB_W;

    // configuration
    logic [TYPE_W-1:0] pool_type_reg;

    // counters
    logic [CNT_W-1:0] free_count_reg, free_count_next;
    logic [CNT_W-1:0] alloc_reg, alloc_next;

    // captured item
    mode_t               mode_reg;
    logic [SUB_W-1:0]    sub_reg;
    logic [HANDLE_W-1:0] handle_reg;

    // result register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [HANDLE_W-1:0] m_handle_reg, m_handle_next;
    status_t             m_status_reg, m_status_next;

    // ram ports
    logic             gen_wr_en;
    logic [IDX_W-1:0] gen_wr_addr;
    logic [GEN_W-1:0] gen_wr_data;
    logic             gen_rd_en;
    logic [IDX_W-1:0] gen_rd_addr;
    logic [GEN_W-1:0] gen_dout;
    logic             stk_wr_en;
    logic             stk_rd_en;
    logic [IDX_W-1:0] stk_rd_addr;
    logic [IDX_W-1:0] stk_dout;

    logic [HANDLE_W-1:0] in_handle;
    logic [HIDX_W-1:0]   h_idx;
    logic [GEN_W-1:0]    h_gen;
    logic                h_valid;
    logic [GEN_W-1:0]    gen_inc;

    assign in_handle = s_tdata[HANDLE_LSB +: HANDLE_W];
    assign h_idx     = handle_reg[HANDLE_W-1:HIDX_LSB];
    assign h_gen     = handle_reg[GEN_W-1:0];
    assign h_valid   = (CNT_W'(h_idx) < alloc_reg) && (gen_dout == h_gen);
    assign gen_inc   = (gen_dout == GEN_W'(GEN_MODULUS - 1)) ? '0 : gen_dout + GEN_W'(1);

    // status to controller
    assign sts.in_mode    = s_tuser;
    assign sts.free_empty = (free_count_reg == '0);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    // read side: stack pop at accept, generation read of handle or popped slot
    assign stk_rd_en   = cmd.stk_rd;
    assign stk_rd_addr = IDX_W'(free_count_reg - CNT_W'(1));
    assign gen_rd_en   = cmd.gen_rd_in || cmd.gen_rd_stk;
    assign gen_rd_addr = cmd.gen_rd_in ? IDX_W'(in_handle[HANDLE_W-1:HIDX_LSB]) : stk_dout;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg   <= mode_t'(s_tuser);
            sub_reg    <= s_tdata[SUB_W-1:0];
            handle_reg <= in_handle;
        end
        m_handle_reg <= m_handle_next;
        m_status_reg <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_type_reg  <= '0;
            free_count_reg <= '0;
            alloc_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                pool_type_reg <= cfg_data;
            end
            free_count_reg <= free_count_next;
            alloc_reg      <= alloc_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // commit: result and state update
    always_comb begin
        free_count_next = free_count_reg;
        alloc_next      = alloc_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_handle_next   = m_handle_reg;
        m_status_next   = m_status_reg;
        gen_wr_en       = 1'b0;
        gen_wr_addr     = h_idx;
        gen_wr_data     = gen_inc;
        stk_wr_en       = 1'b0;
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
            m_handle_next = '0;
            m_status_next = STATUS_INVALID;
            case (mode_reg)
                MODE_BORROW: begin
                    if (free_count_reg != '0) begin
                        free_count_next = free_count_reg - CNT_W'(1);
                        m_handle_next   = {HIDX_W'(stk_dout), pool_type_reg, sub_reg, gen_dout};
                        m_status_next   = STATUS_OK;
                    end else if (alloc_reg < CNT_W'(SLOTS)) begin
                        gen_wr_en     = 1'b1;
                        gen_wr_addr   = IDX_W'(alloc_reg);
                        gen_wr_data   = '0;
                        alloc_next    = alloc_reg + CNT_W'(1);
                        m_handle_next = {HIDX_W'(alloc_reg), pool_type_reg, sub_reg,
                                         GEN_W'(0)};
                        m_status_next = STATUS_OK;
                    end else begin
                        m_status_next = STATUS_EXHAUSTED;
                    end
                end
                MODE_RETURN: begin
                    if (h_valid && (free_count_reg < CNT_W'(SLOTS))) begin
                        gen_wr_en       = 1'b1;
                        stk_wr_en       = 1'b1;
                        free_count_next = free_count_reg + CNT_W'(1);
                        m_status_next   = STATUS_OK;
                    end
                end
                MODE_QUERY: begin
                    m_status_next = h_valid ? STATUS_OK : STATUS_INVALID;
                end
                default: ;
            endcase
        end
    end

    gha_ram #(
        .WIDTH(GEN_W),
        .DEPTH(SLOTS)
    ) u_gen_ram (
        .aclk   (aclk),
        .wr_en  (gen_wr_en),
        .wr_addr(gen_wr_addr),
        .wr_data(gen_wr_data),
        .rd_en  (gen_rd_en),
        .rd_addr(gen_rd_addr),
        .rd_data(gen_dout)
    );

    gha_ram #(
        .WIDTH(IDX_W),
        .DEPTH(SLOTS)
    ) u_stk_ram (
        .aclk   (aclk),
        .wr_en  (stk_wr_en),
        .wr_addr(IDX_W'(free_count_reg)),
        .wr_data(IDX_W'(h_idx)),
        .rd_en  (stk_rd_en),
        .rd_addr(stk_rd_addr),
        .rd_data(stk_dout)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - HANDLE_W){1'b0}}, m_handle_reg};
    assign m_tuser  = m_status_reg;

    `GHA_ASSERT_NOW(a_free_le_slots, 1'b1, free_count_reg <= CNT_W'(SLOTS))
    `GHA_ASSERT_NOW(a_alloc_le_slots, 1'b1, alloc_reg <= CNT_W'(SLOTS))
    `GHA_ASSERT_NOW(a_commit_out_free, cmd.commit, !m_tvalid_reg || m_tready)
    `GHA_ASSERT_NEXT(a_commit_shows, cmd.commit, m_tvalid_reg)
    `GHA_ASSERT_NOW(a_stk_rd_nonempty, cmd.stk_rd, free_count_reg != '0)

endmodule

`default_nettype wire

// ----- hdl/generational_handle_allocator.sv -----
// top level of the generational handle allocator
// depends on gha_pkg, gha_ctrl, gha_dp (and through it gha_ram)
`default_nettype none

// Generational handle allocator. Each item is a request: borrow (tuser 0),
// return (1) or query (2); each gives exactly one result item, the borrowed
// handle on m_tdata and a status on m_tuser (0 ok or valid, 1 pool exhausted,
// 2 invalid handle). A handle packs slot index (bits 41:32), pool type
// (31:28), subtype (27:16) and generation (15:0). Items are handled one at a
// time; from accept, a borrow that pops the free stack passes STK, GEN and
// FIN, a return or query GEN and FIN, and a fresh or exhausted borrow or an
// unknown mode only FIN. STK and GEN cover the registered reads of the free
// stack and then of the slot generation table. A new item is taken while the
// previous result still waits on m_tready; the result register parts the two
// sides. The rams need no clearing after reset, so the block takes items
// right after reset. pool_type is written over the always-ready cfg channel;
// the user must write it only while idle; the block does not enforce this.

module generational_handle_allocator
    import gha_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // request channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // subtype[11:0], handle_in[53:12], zero pad
    input  wire logic [MODE_W-1:0]    s_tuser,   // mode[1:0]
    // result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // handle_out[41:0], zero pad
    output logic      [STATUS_W-1:0]  m_tuser,   // status[1:0]
    // pool_type register write
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [TYPE_W-1:0]    cfg_data   // pool_type[3:0]
);

    cmd_t cmd;   // sequencing commands to the datapath
    sts_t sts;   // incoming mode, stack empty, result register free

    // register write always taken
    assign cfg_ready = 1'b1;

    gha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gha_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// self-checking testbench for generational_handle_allocator
// drives borrow, return and query items and checks each result against a
// behavioral pool model kept here; depends on gha_pkg and the rtl only

module tb_top
    import gha_pkg::*;
;

    localparam logic [MODE_W-1:0]   MODE_UNKNOWN = 2'd3;
    localparam logic [HANDLE_W-1:0] ALL_ONES     = '1;
    localparam int                  STALL_LIMIT  = 2000;
    localparam int                  MAX_REPORTS  = 10;
    localparam int                  DIR_ROWS     = 23;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [STATUS_W-1:0] status;
    } pool_result_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [SUB_W-1:0]    sub;
        logic [HANDLE_W-1:0] hin;
        logic                typed;      // expectation written in the row
        logic [HANDLE_W-1:0] exp_handle;
        logic [STATUS_W-1:0] exp_status;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [MODE_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [TYPE_W-1:0]    cfg_data  = '0;

    // pool model state
    logic [GEN_W-1:0]  slot_gen   [SLOTS];
    logic [IDX_W-1:0]  free_slots [SLOTS];
    logic [CNT_W-1:0]  free_depth  = '0;
    logic [CNT_W-1:0]  alloc_depth = '0;
    logic [TYPE_W-1:0] cur_pool_type = '0;

    pool_result_t        pending_results[$];
    pool_result_t        head_result;
    logic [HANDLE_W-1:0] live_handles[$];
    logic [HANDLE_W-1:0] stale_handles[$];
    dir_row_t            dir_tab[DIR_ROWS];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  err_count      = 0;
    int  stall_cycles   = 0;
    bit  req_held       = 1'b0;

    generational_handle_allocator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // one request applied to the pool model
    function automatic void predict_pool_result(input logic [MODE_W-1:0] mode,
            input logic [SUB_W-1:0] sub, input logic [HANDLE_W-1:0] hin,
            output pool_result_t res);
        logic [IDX_W-1:0] idx;
        logic             hit;
        idx = hin[HANDLE_W-1:HIDX_LSB];
        hit = ({1'b0, idx} < alloc_depth) && (slot_gen[idx] == hin[GEN_W-1:0]);
        res.handle = '0;
        res.status = STATUS_INVALID;
        case (mode)
            MODE_BORROW: begin
                if (free_depth != 0) begin
                    free_depth = free_depth - 1'b1;
                    idx        = free_slots[free_depth[IDX_W-1:0]];
                    res.handle = {idx, cur_pool_type, sub, slot_gen[idx]};
                    res.status = STATUS_OK;
                end else if (alloc_depth < SLOTS) begin
                    idx           = alloc_depth[IDX_W-1:0];
                    slot_gen[idx] = '0;
                    alloc_depth   = alloc_depth + 1'b1;
                    res.handle    = {idx, cur_pool_type, sub, {GEN_W{1'b0}}};
                    res.status    = STATUS_OK;
                end else begin
                    res.status = STATUS_EXHAUSTED;
                end
            end
            MODE_RETURN: begin
                // a full free stack drops even a matching return
                if (hit && free_depth < SLOTS) begin
                    slot_gen[idx] = GEN_W'((32'(slot_gen[idx]) + 1) % GEN_MODULUS);
                    free_slots[free_depth[IDX_W-1:0]] = idx;
                    free_depth = free_depth + 1'b1;
                    res.status = STATUS_OK;
                end
            end
            MODE_QUERY: res.status = hit ? STATUS_OK : STATUS_INVALID;
            default: ;
        endcase
    endfunction

    function automatic void log_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    function automatic logic [HANDLE_W-1:0] rand_handle();
        return HANDLE_W'({$urandom(), $urandom()});
    endfunction

    // matches the current generation of an allocated slot, junk in type and subtype
    function automatic logic [HANDLE_W-1:0] forge_valid();
        logic [IDX_W-1:0] idx;
        idx = IDX_W'($urandom_range(alloc_depth - 1));
        return {idx, TYPE_W'($urandom()), SUB_W'($urandom()), slot_gen[idx]};
    endfunction

    task automatic push_request(input logic [MODE_W-1:0] mode, input logic [SUB_W-1:0] sub,
            input logic [HANDLE_W-1:0] hin, output pool_result_t res);
        while ($urandom_range(99) < send_idle_pct) begin
            if (req_held) begin
                s_tvalid <= 1'b0;
                req_held = 1'b0;
            end
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        req_held = 1'b1;
        s_tuser  <= mode;
        s_tdata  <= S_TDATA_W'({hin, sub});
        do @(posedge aclk); while (!s_tready);
        predict_pool_result(mode, sub, hin, res);
        pending_results.push_back(res);
        // keep the list of outstanding handles in step with the pool
        if (res.status == STATUS_OK && mode == MODE_BORROW) live_handles.push_back(res.handle);
        if (res.status == STATUS_OK && mode == MODE_RETURN) begin
            for (int i = live_handles.size() - 1; i >= 0; i--) begin
                if (live_handles[i][HANDLE_W-1:HIDX_LSB] == hin[HANDLE_W-1:HIDX_LSB]) begin
                    stale_handles.push_back(live_handles[i]);
                    live_handles.delete(i);
                end
            end
        end
        while (stale_handles.size() > 64) void'(stale_handles.pop_front());
    endtask

    task automatic drain_requests();
        if (req_held) begin
            s_tvalid <= 1'b0;
            req_held = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_pool_type(input logic [TYPE_W-1:0] value);
        drain_requests();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cur_pool_type = value;
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed traffic on outstanding handles, 22 percent noise or more
    task automatic run_mixed(input int n_items);
        pool_result_t        res;
        logic [HANDLE_W-1:0] h;
        logic [MODE_W-1:0]   mode;
        int                  pick;
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(63) == 0) drain_requests();
            pick = $urandom_range(99);
            mode = $urandom_range(1) ? MODE_RETURN : MODE_QUERY;
            if (pick < 40) begin
                push_request(MODE_BORROW, SUB_W'($urandom()), rand_handle(), res);
            end else if (pick < 78 && live_handles.size() != 0) begin
                h = live_handles[$urandom_range(live_handles.size() - 1)];
                push_request(pick < 65 ? MODE_RETURN : MODE_QUERY, SUB_W'($urandom()), h, res);
            end else begin
                case ($urandom_range(4))
                    0: h = rand_handle();
                    1: h = stale_handles.size() != 0 ?
                           stale_handles[$urandom_range(stale_handles.size() - 1)] : rand_handle();
                    2: begin
                        h    = rand_handle();
                        mode = MODE_UNKNOWN;
                    end
                    3: h = alloc_depth != 0 ? forge_valid() : rand_handle();
                    default: begin
                        // allocated slot, generation most likely wrong
                        h = rand_handle();
                        if (alloc_depth != 0)
                            h[HANDLE_W-1:HIDX_LSB] = HIDX_W'($urandom_range(alloc_depth - 1));
                    end
                endcase
                push_request(mode, SUB_W'($urandom()), h, res);
            end
        end
    endtask

    // checker and receiver backpressure
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                log_mismatch($sformatf("result with none pending: handle %h status %0d",
                                       m_tdata, m_tuser));
            end else begin
                head_result = pending_results.pop_front();
                if (m_tdata !== M_TDATA_W'(head_result.handle))
                    log_mismatch($sformatf("handle exp %h got %h",
                                           head_result.handle, m_tdata));
                if (m_tuser !== head_result.status)
                    log_mismatch($sformatf("status exp %0d got %0d",
                                           head_result.status, m_tuser));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        pool_result_t        res;
        for (int i = 0; i < SLOTS; i++) begin
            slot_gen[i]   = '0;
            free_slots[i] = '0;
        end
        // handle = {index, type, subtype, generation}; pool type is 0 here
        dir_tab = '{
            // empty pool: nothing is allocated yet
            '{MODE_QUERY,   12'h000, '0, 1'b1, '0, STATUS_INVALID},
            '{MODE_RETURN,  12'h000, '0, 1'b1, '0, STATUS_INVALID},
            '{MODE_UNKNOWN, 12'hfff, ALL_ONES, 1'b1, '0, STATUS_INVALID},
            // fresh slots 0, 1, 2; handle_in ignored on borrow
            '{MODE_BORROW,  12'hfff, ALL_ONES, 1'b1,
              {10'd0, 4'd0, 12'hfff, 16'd0}, STATUS_OK},
            '{MODE_BORROW,  12'h000, '0, 1'b1, {10'd1, 4'd0, 12'h000, 16'd0}, STATUS_OK},
            '{MODE_BORROW,  12'ha5a, '0, 1'b1, {10'd2, 4'd0, 12'ha5a, 16'd0}, STATUS_OK},
            '{MODE_QUERY,   12'hfff, {10'd0, 4'd0, 12'h000, 16'd0}, 1'b1, '0, STATUS_OK},
            // generation mismatch, then an index never allocated
            '{MODE_QUERY,   12'h000, {10'd0, 4'd0, 12'h000, 16'd1}, 1'b1, '0, STATUS_INVALID},
            '{MODE_QUERY,   12'h000, {10'd3, 4'd0, 12'h000, 16'd0}, 1'b1, '0, STATUS_INVALID},
            '{MODE_RETURN,  12'h000, {10'd0, 4'd0, 12'h000, 16'hffff}, 1'b1, '0,
              STATUS_INVALID},
            // type and subtype bits of a returned handle do not matter
            '{MODE_RETURN,  12'h000, {10'd0, 4'hf, 12'hfff, 16'd0}, 1'b1, '0, STATUS_OK},
            '{MODE_QUERY,   12'h000, {10'd0, 4'd0, 12'h000, 16'd0}, 1'b1, '0, STATUS_INVALID},
            '{MODE_RETURN,  12'h000, {10'd0, 4'd0, 12'h000, 16'd0}, 1'b1, '0, STATUS_INVALID},
            '{MODE_RETURN,  12'h000, {10'd1, 4'd0, 12'h000, 16'd0}, 1'b0, '0, STATUS_OK},
            '{MODE_QUERY,   12'h000, {10'd1, 4'd0, 12'h000, 16'd1}, 1'b0, '0, STATUS_OK},
            // lifo reuse: slot 1 then slot 0, both at generation 1
            '{MODE_BORROW,  12'h123, '0, 1'b0, '0, STATUS_OK},
            '{MODE_BORROW,  12'h000, '0, 1'b0, '0, STATUS_OK},
            '{MODE_BORROW,  12'hfff, '0, 1'b1, {10'd3, 4'd0, 12'hfff, 16'd0}, STATUS_OK},
            '{MODE_QUERY,   12'h000, ALL_ONES, 1'b1, '0, STATUS_INVALID},
            '{MODE_RETURN,  12'hfff, {10'h3ff, 4'hf, 12'hfff, 16'd0}, 1'b1, '0,
              STATUS_INVALID},
            '{MODE_UNKNOWN, 12'h000, '0, 1'b1, '0, STATUS_INVALID},
            '{MODE_QUERY,   12'h000, {10'd3, 4'hf, 12'hfff, 16'd0}, 1'b1, '0, STATUS_OK},
            '{MODE_BORROW,  12'h000, '0, 1'b0, '0, STATUS_OK}
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows, no idling
        for (int r = 0; r < DIR_ROWS; r++) begin
            push_request(dir_tab[r].mode, dir_tab[r].sub, dir_tab[r].hin, res);
            // the item was just accepted, so its expectation is still last in line
            if (dir_tab[r].typed)
                pending_results[pending_results.size() - 1] =
                    '{dir_tab[r].exp_handle, dir_tab[r].exp_status};
        end

        // sender idle most of the time
        write_pool_type(4'hf);
        send_idle_pct = 76;
        run_mixed(130);

        // receiver stalling most of the time
        write_pool_type(TYPE_W'($urandom_range(1, 14)));
        send_idle_pct  = 0;
        recv_stall_pct = 76;
        run_mixed(130);

        // light idling on both sides
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        run_mixed(130);

        // full speed on both sides
        write_pool_type(4'h0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_mixed(130);

        drain_requests();
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/gha_pkg.sv
hdl/gha_ram.sv
hdl/gha_ctrl.sv
hdl/gha_dp.sv
hdl/generational_handle_allocator.sv
dv/tb_top.sv
